[sv/nalep_pkg.sv]
// ----------------------------------------------------------------------------
// NAL emulation prevention strip: shared types and constants
// Status codes, unit state and result records used by the parser, the
// output stage and the top level.
// ----------------------------------------------------------------------------
package nalep_pkg;

    // Width of the payload length, the byte count and the capacity register.
    localparam int LenW = 17;

    // Reset value of the capacity register.
    localparam logic [LenW-1:0] CapReset = 17'd65536;

    // Default largest payload of one unit.
    localparam int MaxPayloadDefault = 65536;

    // Largest value that the byte count can hold.
    localparam int CountMax = (1 << LenW) - 1;

    // Result status codes.
    localparam logic [1:0] StOk         = 2'd0;
    localparam logic [1:0] StForbidden  = 2'd1;
    localparam logic [1:0] StBadEscape  = 2'd2;
    localparam logic [1:0] StOverflow   = 2'd3;

    // Byte values with a meaning in the stream.
    localparam logic [7:0] ByteZero     = 8'h00;
    localparam logic [7:0] ByteEscape   = 8'h03;

    // Header bytes at the start of every unit.
    localparam logic [1:0] HeaderBytes  = 2'd2;

    // Longest zero run that is tracked; longer runs saturate here.
    localparam logic [1:0] ZeroRunSat   = 2'd3;

    // Per-unit parser state.
    typedef struct packed {
        logic [1:0]      header_seen;
        logic [1:0]      zero_run;
        logic            escape_pending;
        logic [LenW-1:0] emitted_count;
        logic            drain_after_error;
    } t_state;

    // One result beat.
    typedef struct packed {
        logic [7:0]      out_byte;
        logic            out_valid;
        logic            out_end;
        logic [1:0]      out_status;
        logic [LenW-1:0] out_length;
    } t_result;

endpackage

[sv/nalep_parse.sv]
// ----------------------------------------------------------------------------
// NAL emulation prevention strip: byte parser
// Works out, from the unit state and one input byte, the next state and
// whether a result beat is produced and what it carries.
// ----------------------------------------------------------------------------
module nalep_parse (
    input  nalep_pkg::t_state              i_state,
    input  logic [7:0]                     i_byte,
    input  logic                           i_last,
    input  logic [nalep_pkg::LenW-1:0]     i_limit,
    output nalep_pkg::t_state              o_state,
    output logic                           o_has_result,
    output nalep_pkg::t_result             o_result
);
    import nalep_pkg::*;

    logic            do_emit;
    logic            do_fail;
    logic [1:0]      fail_status;
    logic            do_end_ok;
    t_state          st;
    logic [LenW-1:0] count_inc;

    assign count_inc = i_state.emitted_count + 1'b1;

    // Classify the byte: emit, fail, silent drop or short end.
    always_comb begin
        st          = i_state;
        do_emit     = 1'b0;
        do_fail     = 1'b0;
        fail_status = StOk;
        do_end_ok   = 1'b0;

        if (i_state.drain_after_error) begin
            // Rest of a failed unit is ignored.
        end else if (i_state.header_seen < HeaderBytes) begin
            st.header_seen = i_state.header_seen + 1'b1;
            do_end_ok      = i_last;
        end else if (i_state.escape_pending) begin
            st.escape_pending = 1'b0;
            if (i_byte > ByteEscape) begin
                do_fail     = 1'b1;
                fail_status = StBadEscape;
            end else begin
                st.zero_run = (i_byte == ByteZero) ? 2'd1 : 2'd0;
                do_emit     = 1'b1;
            end
        end else if (i_byte == ByteZero) begin
            if (i_state.zero_run < ZeroRunSat) begin
                st.zero_run = i_state.zero_run + 1'b1;
            end
            do_emit = 1'b1;
        end else if (i_state.zero_run == ZeroRunSat) begin
            do_fail     = 1'b1;
            fail_status = StForbidden;
        end else if (i_state.zero_run == 2'd2 && i_byte < ByteEscape) begin
            do_fail     = 1'b1;
            fail_status = StForbidden;
        end else if (i_state.zero_run == 2'd2 && i_byte == ByteEscape) begin
            // Emulation prevention byte: removed.
            st.zero_run       = 2'd0;
            st.escape_pending = !i_last;
            do_end_ok         = i_last;
        end else begin
            st.zero_run = 2'd0;
            do_emit     = 1'b1;
        end

        // An emitted byte beyond the limit turns into an overflow.
        if (do_emit && i_state.emitted_count >= i_limit) begin
            do_emit     = 1'b0;
            do_fail     = 1'b1;
            fail_status = StOverflow;
        end
        if (do_emit) begin
            st.emitted_count = count_inc;
        end
        if (do_fail && !i_last) begin
            st.drain_after_error = 1'b1;
        end
    end

    // Result beat and end-of-unit clearing.
    always_comb begin
        o_has_result        = do_emit || do_fail || do_end_ok;
        o_result.out_byte   = do_emit ? i_byte : 8'h00;
        o_result.out_valid  = do_emit;
        o_result.out_end    = do_fail || do_end_ok || (do_emit && i_last);
        o_result.out_status = do_fail ? fail_status : StOk;
        o_result.out_length = st.emitted_count;
        if (i_last) begin
            o_state = '0;
        end else begin
            o_state = st;
        end
    end

endmodule

[sv/nalep_out_reg.sv]
// ----------------------------------------------------------------------------
// NAL emulation prevention strip: result register
// One-entry output register; it takes a new result in the same cycle as
// the held one leaves.
// ----------------------------------------------------------------------------
module nalep_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  nalep_pkg::t_result  i_result,
    input  logic                i_take,
    output logic                o_free,
    output logic                o_valid,
    output nalep_pkg::t_result  o_result
);
    import nalep_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    // Free when empty or when the held beat is taken this cycle.
    assign o_free = !r_valid || i_take;

    always_comb begin
        n_valid = r_valid;
        if (o_free) begin
            n_valid = i_load;
        end
    end

    // Occupancy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

[sv/nal_emulation_prevention_strip.sv]
// ----------------------------------------------------------------------------
// NAL emulation prevention strip
// Removes the header and the emulation prevention bytes from a NAL unit.
// ----------------------------------------------------------------------------
// Takes one byte of a NAL unit per beat, marked last on its final byte, and
// gives one result beat per payload byte plus an end beat carrying status
// and payload length (the final payload byte carries the end itself). A
// byte is taken every cycle while the result side keeps up; its result sits
// in the output register in the cycle after the input beat, and the parse of a
// byte is one pass of logic on the unit state, so the rate is one beat per
// cycle. After an error the remaining bytes of the unit give no beats.
module nal_emulation_prevention_strip #(
    parameter int MAX_PAYLOAD = nalep_pkg::MaxPayloadDefault
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Capacity register write.
    input  logic                         i_cfg_wr_en,
    input  logic [nalep_pkg::LenW-1:0]   i_cfg_wr_data,
    // Input bytes.
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,   // [7:0] in_byte
    input  logic                         s_axis_tlast,   // in_last
    // Result beats.
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [7:0] out_byte, [9:8] out_status, [26:10] out_length, [31:27] zero
    output logic [31:0]                  m_axis_tdata,
    output logic                         m_axis_tuser,   // out_valid
    output logic                         m_axis_tlast    // out_end
);
    import nalep_pkg::*;

    // Payload limit fixed at elaboration, clipped to what the count can hold.
    localparam int LimClip = (MAX_PAYLOAD > CountMax) ? CountMax : MAX_PAYLOAD;
    localparam logic [LenW-1:0] MaxLimit = LenW'(LimClip);

    logic [LenW-1:0] r_capacity;
    logic [LenW-1:0] limit;
    t_state          r_state;
    t_state          n_state;
    logic            has_result;
    t_result         result;
    t_result         out_result;
    logic            out_free;
    logic            in_beat;

    assign s_axis_tready = out_free;
    assign in_beat       = s_axis_tvalid && out_free;
    assign limit         = (r_capacity > MaxLimit) ? MaxLimit : r_capacity;

    // Capacity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CapReset;
        end else if (i_cfg_wr_en) begin
            r_capacity <= i_cfg_wr_data;
        end
    end

    // Unit state advances on every accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_beat) begin
            r_state <= n_state;
        end
    end

    nalep_parse u_parse (
        .i_state      (r_state),
        .i_byte       (s_axis_tdata),
        .i_last       (s_axis_tlast),
        .i_limit      (limit),
        .o_state      (n_state),
        .o_has_result (has_result),
        .o_result     (result)
    );

    nalep_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (in_beat && has_result),
        .i_result (result),
        .i_take   (m_axis_tready),
        .o_free   (out_free),
        .o_valid  (m_axis_tvalid),
        .o_result (out_result)
    );

    // Pack the result beat.
    assign m_axis_tdata = {5'd0, out_result.out_length, out_result.out_status,
                           out_result.out_byte};
    assign m_axis_tuser = out_result.out_valid;
    assign m_axis_tlast = out_result.out_end;

endmodule

[bench/tb_nal_emulation_prevention_strip.sv]
// ----------------------------------------------------------------------------
// Testbench for the NAL emulation prevention strip
// Feeds whole NAL units as byte beats, predicts every result beat from a
// behavioural model of the stripping rules and checks each one field by
// field, across several settings of the capacity register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_nal_emulation_prevention_strip;

    import nalep_pkg::*;

    localparam int MaxPayload  = MaxPayloadDefault;
    localparam int RandomItems = 1100;
    localparam int CycleLimit  = 200000;
    localparam int SettleDelay = 4;

    // One input beat: a raw NAL byte and its end-of-unit mark.
    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_nal_beat;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_wr_en = 1'b0;
    logic [LenW-1:0]   i_cfg_wr_data = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata = '0;   // [7:0] in_byte
    logic              s_axis_tlast = 1'b0; // in_last
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // [7:0] out_byte, [9:8] out_status, [26:10] out_length, [31:27] zero
    logic [31:0]       m_axis_tdata;
    logic              m_axis_tuser;        // out_valid
    logic              m_axis_tlast;        // out_end

    t_nal_beat         beats_pending[$];
    t_result           results_expected[$];
    logic [7:0]        unit_bytes[$];
    t_nal_beat         next_beat;
    t_state            unit_st = '0;
    logic [LenW-1:0]   capacity_model = CapReset;
    logic              in_took = 1'b0;
    logic              quiet = 1'b0;
    int                mismatches = 0;
    int                items_queued = 0;
    int                cycles = 0;

    nal_emulation_prevention_strip #(
        .MAX_PAYLOAD (MaxPayload)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Free-running clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Run guard.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("FAIL");
            $finish;
        end
    end

    // Ends the unit with an error status; the rest of the unit is skipped.
    function automatic t_result unit_error(input logic [1:0] status, input logic last);
        t_result r;
        r = '0;
        r.out_end    = 1'b1;
        r.out_status = status;
        r.out_length = unit_st.emitted_count;
        if (last) begin
            unit_st = '0;
        end else begin
            unit_st.drain_after_error = 1'b1;
        end
        return r;
    endfunction

    // Emits one payload byte, or flags overflow once the limit is reached.
    function automatic t_result emit_payload(input logic [7:0] value, input logic last);
        t_result         r;
        logic [LenW:0]   limit;
        limit = (capacity_model > MaxPayload) ? (LenW+1)'(MaxPayload)
                                              : {1'b0, capacity_model};
        if ({1'b0, unit_st.emitted_count} >= limit) begin
            return unit_error(StOverflow, last);
        end
        unit_st.emitted_count = unit_st.emitted_count + 1'b1;
        r = '0;
        r.out_byte   = value;
        r.out_valid  = 1'b1;
        r.out_end    = last;
        r.out_length = unit_st.emitted_count;
        if (last) begin
            unit_st = '0;
        end
        return r;
    endfunction

    // Advances the unit state by one accepted byte and queues any result.
    task automatic strip_predict(input logic [7:0] value, input logic last);
        t_result r;
        logic    give;
        r = '0;
        give = 1'b0;
        if (unit_st.drain_after_error) begin
            if (last) begin
                unit_st = '0;
            end
        end else if (unit_st.header_seen < HeaderBytes) begin
            unit_st.header_seen = unit_st.header_seen + 1'b1;
            if (last) begin
                // A unit that ends inside its header.
                r.out_end = 1'b1;
                r.out_status = StOk;
                r.out_length = unit_st.emitted_count;
                unit_st = '0;
                give = 1'b1;
            end
        end else if (unit_st.escape_pending) begin
            unit_st.escape_pending = 1'b0;
            give = 1'b1;
            if (value > ByteEscape) begin
                r = unit_error(StBadEscape, last);
            end else begin
                unit_st.zero_run = (value == ByteZero) ? 2'd1 : 2'd0;
                r = emit_payload(value, last);
            end
        end else if (value == ByteZero) begin
            if (unit_st.zero_run < ZeroRunSat) begin
                unit_st.zero_run = unit_st.zero_run + 1'b1;
            end
            r = emit_payload(value, last);
            give = 1'b1;
        end else if (unit_st.zero_run == ZeroRunSat) begin
            r = unit_error(StForbidden, last);
            give = 1'b1;
        end else if (unit_st.zero_run == 2'd2 && value < ByteEscape) begin
            r = unit_error(StForbidden, last);
            give = 1'b1;
        end else if (unit_st.zero_run == 2'd2 && value == ByteEscape) begin
            // Escape byte: removed; at the end of the unit it closes it.
            unit_st.zero_run = 2'd0;
            if (last) begin
                r.out_end = 1'b1;
                r.out_status = StOk;
                r.out_length = unit_st.emitted_count;
                unit_st = '0;
                give = 1'b1;
            end else begin
                unit_st.escape_pending = 1'b1;
            end
        end else begin
            unit_st.zero_run = 2'd0;
            r = emit_payload(value, last);
            give = 1'b1;
        end
        if (give) begin
            results_expected.push_back(r);
        end
    endtask

    // Reports one field that differs from its prediction.
    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Output check first, then prediction of the byte taken at this edge.
    always @(posedge i_clk) begin : monitor
        t_result want;
        in_took <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (results_expected.size() == 0) begin
                $error("result beat with no expectation: tdata %h", m_axis_tdata);
                mismatches++;
            end else begin
                want = results_expected.pop_front();
                check_field("out_byte", want.out_byte, m_axis_tdata[7:0]);
                check_field("out_valid", want.out_valid, m_axis_tuser);
                check_field("out_end", want.out_end, m_axis_tlast);
                check_field("out_status", want.out_status, m_axis_tdata[9:8]);
                check_field("out_length", want.out_length, m_axis_tdata[26:10]);
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            strip_predict(s_axis_tdata, s_axis_tlast);
        end
    end

    // Byte driver and result-side back-pressure, both at the falling edge.
    always @(negedge i_clk) begin
        if (!s_axis_tvalid || in_took) begin
            if (i_rst_n && beats_pending.size() > 0 && (quiet || $urandom_range(99) >= 16)) begin
                next_beat = beats_pending.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= next_beat.value;
                s_axis_tlast  <= next_beat.last;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= quiet || ($urandom_range(99) >= 16);
    end

    // Moves the bytes of the unit under construction to the driver queue.
    task automatic send_unit();
        t_nal_beat b;
        foreach (unit_bytes[k]) begin
            b.value = unit_bytes[k];
            b.last  = (k == unit_bytes.size() - 1);
            beats_pending.push_back(b);
        end
        items_queued += unit_bytes.size();
        unit_bytes.delete();
    endtask

    // Builds a random unit, mostly well formed, with some broken sequences.
    task automatic random_unit();
        int pieces;
        unit_bytes.delete();
        unit_bytes.push_back(8'($urandom_range(0, 255)));
        unit_bytes.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(15) == 0) begin
            // Unit cut short inside the header.
            if ($urandom_range(1) == 0) begin
                void'(unit_bytes.pop_back());
            end
        end else begin
            pieces = $urandom_range(0, 7);
            repeat (pieces) begin
                case ($urandom_range(9))
                    0, 1, 2, 3: unit_bytes.push_back(8'($urandom_range(0, 255)));
                    4: unit_bytes.push_back(ByteZero);
                    5, 6: begin
                        unit_bytes.push_back(ByteZero);
                        unit_bytes.push_back(ByteZero);
                        unit_bytes.push_back(ByteEscape);
                        if ($urandom_range(7) == 0) begin
                            unit_bytes.push_back(8'($urandom_range(4, 255)));
                        end else begin
                            unit_bytes.push_back(8'($urandom_range(0, 3)));
                        end
                    end
                    7: begin
                        unit_bytes.push_back(ByteZero);
                        unit_bytes.push_back(ByteZero);
                        unit_bytes.push_back(8'($urandom_range(4, 255)));
                    end
                    8: begin
                        unit_bytes.push_back(ByteZero);
                        unit_bytes.push_back(ByteZero);
                        unit_bytes.push_back(8'($urandom_range(0, 2)));
                    end
                    default: begin
                        repeat ($urandom_range(3, 4)) unit_bytes.push_back(ByteZero);
                    end
                endcase
            end
            // Endings: escape at the end, trailing zeros, or none.
            case ($urandom_range(5))
                0: begin
                    unit_bytes.push_back(ByteZero);
                    unit_bytes.push_back(ByteZero);
                    unit_bytes.push_back(ByteEscape);
                end
                1: repeat ($urandom_range(1, 4)) unit_bytes.push_back(ByteZero);
                default: ;
            endcase
        end
        send_unit();
    endtask

    // Waits until every byte is taken and every result has come, then settles.
    task automatic wait_idle();
        while (beats_pending.size() != 0 || s_axis_tvalid || results_expected.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SettleDelay) @(negedge i_clk);
    endtask

    // Capacity register write, only while the block is idle.
    task automatic write_capacity(input logic [LenW-1:0] value);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        capacity_model = value;
    endtask

    // Test sequence.
    initial begin : sequencer
        int phase;
        int phase_start;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed units at the reset capacity.
        unit_bytes = '{8'h7f};
        send_unit();
        unit_bytes = '{8'h40, 8'h01, 8'h00, 8'h00, 8'h03, 8'h00, 8'h00, 8'h03};
        send_unit();
        unit_bytes = '{8'h40, 8'h01, 8'h00, 8'h00, 8'h00, 8'hff, 8'h12};
        send_unit();
        unit_bytes = '{8'h40, 8'h01, 8'h00, 8'h00, 8'h01};
        send_unit();
        unit_bytes = '{8'h40, 8'h01, 8'h00, 8'h00, 8'h03, 8'hfc};
        send_unit();
        wait_idle();

        // Overflow inside a zero run, then with no room at all.
        write_capacity(17'd2);
        unit_bytes = '{8'h40, 8'h01, 8'h00, 8'h00, 8'h00, 8'h05};
        send_unit();
        wait_idle();
        write_capacity(17'd0);
        unit_bytes = '{8'h40, 8'h01, 8'h07, 8'h00};
        send_unit();
        wait_idle();

        // Random phases, each under its own capacity setting.
        items_queued = 0;
        phase = 0;
        while (items_queued < RandomItems) begin
            case (phase)
                0: write_capacity(CapReset);
                1: write_capacity(17'd1);
                2: write_capacity(17'd0);
                3: write_capacity(CapReset);
                default: begin
                    if ($urandom_range(2) == 0) begin
                        write_capacity(LenW'($urandom_range(0, 16)));
                    end else begin
                        write_capacity(LenW'($urandom_range(17, 65536)));
                    end
                end
            endcase
            quiet = (phase == 3);
            phase_start = items_queued;
            while (items_queued - phase_start < 140) begin
                random_unit();
            end
            wait_idle();
            quiet = 1'b0;
            phase++;
        end

        wait_idle();
        repeat (10) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
